@@ rtl/core/ssdm_pkg.sv @@
package ssdm_pkg;

  // command codes carried in tuser
  localparam logic [2:0] CMD_ELECTRON = 3'd0;
  localparam logic [2:0] CMD_MUON     = 3'd1;
  localparam logic [2:0] CMD_JET      = 3'd2;
  localparam logic [2:0] CMD_MET      = 3'd3;
  localparam logic [2:0] CMD_END      = 3'd4;

  // verdict codes
  localparam logic [2:0] VERDICT_ACCEPT        = 3'd0;
  localparam logic [2:0] VERDICT_ELECTRON_VETO = 3'd1;
  localparam logic [2:0] VERDICT_FEW_MUONS     = 3'd2;
  localparam logic [2:0] VERDICT_MUON_COUNT    = 3'd3;
  localparam logic [2:0] VERDICT_CHARGE        = 3'd4;
  localparam logic [2:0] VERDICT_FEW_JETS      = 3'd5;

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_ELECTRON_THR = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MUON_THR     = 1'd1;
  localparam logic [15:0] THR_RESET = 16'd80;

  localparam int MAX_OBJECTS_DEFAULT = 256;
  localparam logic [19:0] MET_MAX = 20'hFFFFF;
  localparam logic [1:0] GOOD_SAT = 2'd3;
  localparam logic [1:0] GOOD_PAIR = 2'd2;
  localparam logic [7:0] TWO = 8'd2;

  typedef struct packed {
    logic        valid;
    logic [7:0]  index;
    logic [15:0] pt;
    logic [1:0]  charge;
  } slot_t;

  // what one cell hands to its neighbor; disp marks an object pushed down from above
  typedef struct packed {
    logic  item;
    logic  eoe;
    logic  disp;
    slot_t cand;
  } tok_t;

  // empty slots read as zero
  function automatic slot_t slot_view(input slot_t s);
    slot_t r;
    r = s;
    if (!s.valid) begin
      r = '0;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/ssdm_cell.sv @@
module ssdm_cell
  import ssdm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  tok_t  tok_in,
  output tok_t  tok_out,
  output slot_t slot,
  output slot_t held
);

  logic take;

  // a new object needs strictly higher pt, one pushed down from the cell above
  // was earlier than the held one and wins a tie
  assign take = tok_in.item && (!slot.valid || tok_in.cand.pt > slot.pt ||
                                (tok_in.disp && tok_in.cand.pt == slot.pt));

  // keep the higher candidate, pass the other one on
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
      tok_out.item <= 1'b0;
      tok_out.eoe <= 1'b0;
    end else if (en) begin
      if (tok_in.eoe) begin
        held <= slot;
        slot.valid <= 1'b0;
        tok_out <= tok_in;
      end else if (take) begin
        slot <= tok_in.cand;
        tok_out.item <= slot.valid;
        tok_out.eoe <= 1'b0;
        tok_out.disp <= 1'b1;
        tok_out.cand <= slot;
      end else begin
        tok_out <= tok_in;
      end
    end
  end

endmodule

@@ rtl/core/same_sign_dimuon_event_selector_unit.sv @@
// the result of an end-of-event request is registered once its end token has left the first ranking cell
// throughput: one object request per cycle while the input is not stalled, events back to back
// the rate is set by the two-cell ranking chains, one compare per cell per cycle
// input stalls only when an end-of-event token leaves the first cell while a result waits
// reset (rst, synchronous): thresholds to 80, tallies and sums cleared, slots empty, no result
module same_sign_dimuon_event_selector_unit
  import ssdm_pkg::*;
#(
  parameter int MAX_OBJECTS_PER_KIND = MAX_OBJECTS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [23:0]            s_tdata,   // pt[15:0], charge[17:16], prompt[18], zero fill
  input  logic [2:0]             s_tuser,   // command[2:0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [127:0]           m_tdata    // verdict[2:0], lead_muon_index[10:3],
                                            // lead_muon_pt[26:11], lead_muon_charge[28:27],
                                            // sub_muon_index[36:29], sub_muon_pt[52:37],
                                            // sub_muon_charge[54:53], lead_jet_index[62:55],
                                            // lead_jet_pt[78:63], sub_jet_index[86:79],
                                            // sub_jet_pt[102:87], missing_et_sum[122:103]
);

  // raw muon and jet tallies saturate at one below the per-kind limit, never above 255
  localparam int CAP_INT = (MAX_OBJECTS_PER_KIND - 1 > 255) ? 255 : MAX_OBJECTS_PER_KIND - 1;
  localparam logic [7:0] TALLY_CAP = 8'(CAP_INT);

  // event summary captured when the end marker is accepted
  typedef struct packed {
    logic        eseen;
    logic        raw_few;
    logic [1:0]  good;
    logic        jet_few;
    logic [19:0] met;
  } snap_t;

  logic [15:0] electron_thr;
  logic [15:0] muon_thr;

  logic        electron_seen;
  logic [7:0]  raw_muon_tally;
  logic [1:0]  good_muon_tally;
  logic [7:0]  jet_tally;
  logic [19:0] met_acc;
  snap_t       snap;

  logic [2:0]  cmd;
  logic [15:0] pt;
  logic [1:0]  charge;
  logic        prompt;
  logic        accept;
  logic        en;
  logic        muon_good;
  logic [20:0] met_sum;
  logic [19:0] met_next;

  tok_t  mu_in, mu_t1, mu_t2;
  tok_t  jt_in, jt_t1, jt_t2;
  slot_t mu0_slot, mu0_held, mu1_slot, mu1_held;
  slot_t jt0_slot, jt0_held, jt1_slot, jt1_held;
  slot_t lead_mu, sub_mu, lead_jt, sub_jt;
  logic [2:0] verdict;

  assign cmd    = s_tuser;
  assign pt     = s_tdata[15:0];
  assign charge = s_tdata[17:16];
  assign prompt = s_tdata[18];

  // hold everything only when a finished event would land on an untaken result
  assign en       = !(m_tvalid && !m_tready && mu_t1.eoe);
  assign s_tready = en;
  assign accept   = s_tvalid && s_tready;

  assign muon_good = prompt && (pt >= muon_thr);
  assign met_sum   = {1'b0, met_acc} + {5'b0, pt};
  assign met_next  = met_sum[20] ? MET_MAX : met_sum[19:0];

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      electron_thr <= THR_RESET;
      muon_thr <= THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ELECTRON_THR: electron_thr <= cfg_data;
        REG_MUON_THR:     muon_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-event tallies, cleared as the end marker passes
  always_ff @(posedge clk) begin
    if (rst) begin
      electron_seen <= 1'b0;
      raw_muon_tally <= '0;
      good_muon_tally <= '0;
      jet_tally <= '0;
      met_acc <= '0;
    end else if (accept) begin
      unique case (cmd)
        CMD_ELECTRON: begin
          if (pt >= electron_thr) begin
            electron_seen <= 1'b1;
          end
        end
        CMD_MUON: begin
          if (muon_good && good_muon_tally != GOOD_SAT) begin
            good_muon_tally <= good_muon_tally + 2'd1;
          end
          if (raw_muon_tally < TALLY_CAP) begin
            raw_muon_tally <= raw_muon_tally + 8'd1;
          end
        end
        CMD_JET: begin
          if (jet_tally < TALLY_CAP) begin
            jet_tally <= jet_tally + 8'd1;
          end
        end
        CMD_MET: met_acc <= met_next;
        CMD_END: begin
          electron_seen <= 1'b0;
          raw_muon_tally <= '0;
          good_muon_tally <= '0;
          jet_tally <= '0;
          met_acc <= '0;
        end
        default: ;
      endcase
    end
  end

  // summary travels alongside the first cell's output token
  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_END) begin
      snap.eseen <= electron_seen;
      snap.raw_few <= raw_muon_tally < TWO;
      snap.good <= good_muon_tally;
      snap.jet_few <= jet_tally < TWO;
      snap.met <= met_acc;
    end
  end

  // candidates entering the ranking chains
  always_comb begin
    mu_in.item = accept && cmd == CMD_MUON && muon_good;
    mu_in.eoe = accept && cmd == CMD_END;
    mu_in.disp = 1'b0;
    mu_in.cand.valid = 1'b1;
    mu_in.cand.index = raw_muon_tally;
    mu_in.cand.pt = pt;
    mu_in.cand.charge = charge;
    jt_in.item = accept && cmd == CMD_JET;
    jt_in.eoe = accept && cmd == CMD_END;
    jt_in.disp = 1'b0;
    jt_in.cand.valid = 1'b1;
    jt_in.cand.index = jet_tally;
    jt_in.cand.pt = pt;
    jt_in.cand.charge = 2'b00;
  end

  // muon chain: cell 0 keeps the leader, cell 1 the runner-up
  ssdm_cell u_mu0 (
    .clk(clk), .rst(rst), .en(en), .tok_in(mu_in), .tok_out(mu_t1),
    .slot(mu0_slot), .held(mu0_held)
  );
  ssdm_cell u_mu1 (
    .clk(clk), .rst(rst), .en(en), .tok_in(mu_t1), .tok_out(mu_t2),
    .slot(mu1_slot), .held(mu1_held)
  );

  // jet chain
  ssdm_cell u_jt0 (
    .clk(clk), .rst(rst), .en(en), .tok_in(jt_in), .tok_out(jt_t1),
    .slot(jt0_slot), .held(jt0_held)
  );
  ssdm_cell u_jt1 (
    .clk(clk), .rst(rst), .en(en), .tok_in(jt_t1), .tok_out(jt_t2),
    .slot(jt1_slot), .held(jt1_held)
  );

  // when the end token sits between the cells: leader was captured by cell 0,
  // runner-up is still live in cell 1
  assign lead_mu = slot_view(mu0_held);
  assign sub_mu  = slot_view(mu1_slot);
  assign lead_jt = slot_view(jt0_held);
  assign sub_jt  = slot_view(jt1_slot);

  always_comb begin
    priority if (snap.eseen) begin
      verdict = VERDICT_ELECTRON_VETO;
    end else if (snap.raw_few) begin
      verdict = VERDICT_FEW_MUONS;
    end else if (snap.good != GOOD_PAIR) begin
      verdict = VERDICT_MUON_COUNT;
    end else if (lead_mu.charge != sub_mu.charge) begin
      verdict = VERDICT_CHARGE;
    end else if (snap.jet_few) begin
      verdict = VERDICT_FEW_JETS;
    end else begin
      verdict = VERDICT_ACCEPT;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en && mu_t1.eoe) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && mu_t1.eoe) begin
      m_tdata <= {5'b0, snap.met,
                  sub_jt.pt, sub_jt.index, lead_jt.pt, lead_jt.index,
                  sub_mu.charge, sub_mu.pt, sub_mu.index,
                  lead_mu.charge, lead_mu.pt, lead_mu.index,
                  verdict};
    end
  end

`ifndef NO_ASSERTIONS
  // both chains carry the end marker in step
  a_chain_aligned: assert property (@(posedge clk) disable iff (rst)
    mu_t1.eoe == jt_t1.eoe && mu_t2.eoe == jt_t2.eoe)
    else $error("ranking chains out of step");

  // the input only stalls behind an untaken result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a waiting result");

  // an accepted event always has a same-sign pair
  a_accept_same_sign: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:0] == VERDICT_ACCEPT) |-> (m_tdata[28:27] == m_tdata[54:53]))
    else $error("accepted event with opposite charges");

  // a new result appears only after an end token left the first cell
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(mu_t1.eoe))
    else $error("result without end of event");
`endif

endmodule
